// ===== rtl/core/rws_pkg.sv =====
// rws_pkg: shared constants and types for the round-trip-time window statistics block
// no dependencies; used by rws_ctrl, rws_datapath and rtt_window_statistics_top
package rws_pkg;

  // number of samples held in the ring
  localparam int unsigned WINDOW    = 8;
  localparam int unsigned RTT_W     = 32;
  localparam int unsigned SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W     = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W     = RTT_W + $clog2(WINDOW);
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the sample and read the oldest ring entry
    logic update;    // retire the oldest entry, store the sample, seed the divider
    logic div_step;  // one restoring division step
    logic load_out;  // copy the results into the output registers
  } rws_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_nonzero;  // the offered sample is a real measurement
    logic div_last;    // the current division step is the final one
  } rws_status_t;

endpackage

// ===== rtl/core/rtt_window_statistics_top.sv =====
// a result follows its sample through the window update, the division steps and the hand-off
// the bit-serial divider holds off a new sample until the last result has been handed off
// zero samples are taken while idle and give no result
// reset: synchronous active-low; clears ring valid bits, sum, count, slot, min (all ones), max
// the output register lets a new sample be taken while a result still waits
// depends on rws_pkg, rws_ctrl and rws_datapath
module rtt_window_statistics_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rws_pkg::RTT_W-1:0] in_rtt_sample,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rws_pkg::RTT_W-1:0] out_average_rtt,
  output logic [rws_pkg::RTT_W-1:0] out_minimum_rtt,
  output logic [rws_pkg::RTT_W-1:0] out_maximum_rtt
);

  rws_pkg::rws_cmd_t    cmd;
  rws_pkg::rws_status_t status;

  // sequencing: idle, window update, division steps, result hand-off
  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // ring, incremental sum and count, min/max tracking and the divider
  rws_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_rtt_sample   (in_rtt_sample),
    .out_average_rtt (out_average_rtt),
    .out_minimum_rtt (out_minimum_rtt),
    .out_maximum_rtt (out_maximum_rtt)
  );

endmodule

// ===== rtl/core/rws_ctrl.sv =====
// rws_ctrl: sequencing state machine and output handshake for the rtt window statistics
// depends on rws_pkg
module rws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  rws_pkg::rws_status_t status,
  output rws_pkg::rws_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        // a zero sample is taken and dropped
        if (in_valid && status.in_nonzero) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/rws_datapath.sv =====
// rws_datapath: sample ring, running sum and count, min/max and bit-serial divider
// depends on rws_pkg; driven by rws_ctrl commands
module rws_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rws_pkg::rws_cmd_t           cmd,
  output rws_pkg::rws_status_t        status,
  input  logic [rws_pkg::RTT_W-1:0]   in_rtt_sample,
  output logic [rws_pkg::RTT_W-1:0]   out_average_rtt,
  output logic [rws_pkg::RTT_W-1:0]   out_minimum_rtt,
  output logic [rws_pkg::RTT_W-1:0]   out_maximum_rtt
);

  localparam int unsigned RTT_W     = rws_pkg::RTT_W;
  localparam int unsigned SLOT_W    = rws_pkg::SLOT_W;
  localparam int unsigned CNT_W     = rws_pkg::CNT_W;
  localparam int unsigned SUM_W     = rws_pkg::SUM_W;
  localparam int unsigned DIV_CNT_W = rws_pkg::DIV_CNT_W;
  localparam int unsigned WINDOW    = rws_pkg::WINDOW;

  // ring storage and per-entry valid bits
  logic [RTT_W-1:0]     ring_mem [WINDOW];
  logic [WINDOW-1:0]    ring_vld_r;
  logic [WINDOW-1:0]    ring_vld_nxt;

  logic [RTT_W-1:0]     sample_r;
  logic [RTT_W-1:0]     rd_data_r;
  logic                 rd_vld_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    slot_nxt;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [RTT_W-1:0]     lowest_r;
  logic [RTT_W-1:0]     lowest_nxt;
  logic [RTT_W-1:0]     highest_r;
  logic [RTT_W-1:0]     highest_nxt;
  logic [RTT_W-1:0]     evicted;

  // divider
  logic [SUM_W-1:0]     quo_r;
  logic [SUM_W-1:0]     quo_nxt;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIV_CNT_W-1:0] div_cnt_nxt;
  logic [CNT_W:0]       rem_shift;
  logic [CNT_W:0]       rem_diff;
  logic                 rem_ge;

  logic [RTT_W-1:0]     out_average_r;
  logic [RTT_W-1:0]     out_minimum_r;
  logic [RTT_W-1:0]     out_maximum_r;

  assign status.in_nonzero = (in_rtt_sample != '0);
  assign status.div_last   = (div_cnt_r == '0);

  assign out_average_rtt = out_average_r;
  assign out_minimum_rtt = out_minimum_r;
  assign out_maximum_rtt = out_maximum_r;

  // window update arithmetic
  always_comb begin
    evicted   = rd_vld_r ? rd_data_r : '0;
    count_nxt = rd_vld_r ? count_r : count_r + CNT_W'(1);
    sum_nxt   = sum_r - SUM_W'(evicted) + SUM_W'(sample_r);
    slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
    lowest_nxt  = (sample_r < lowest_r) ? sample_r : lowest_r;
    highest_nxt = (sample_r > highest_r) ? sample_r : highest_r;
    ring_vld_nxt         = ring_vld_r;
    ring_vld_nxt[slot_r] = 1'b1;
  end

  // restoring division, one quotient bit a step
  always_comb begin
    rem_shift   = {rem_r, quo_r[SUM_W-1]};
    rem_ge      = (rem_shift >= {1'b0, count_r});
    rem_diff    = rem_shift - {1'b0, count_r};
    rem_nxt     = rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    quo_nxt     = {quo_r[SUM_W-2:0], rem_ge};
    div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring_mem[slot_r] <= sample_r;
    end
    if (cmd.capture) begin
      rd_data_r <= ring_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      slot_r     <= '0;
      sum_r      <= '0;
      count_r    <= '0;
      lowest_r   <= '1;
      highest_r  <= '0;
    end else if (cmd.update) begin
      ring_vld_r <= ring_vld_nxt;
      slot_r     <= slot_nxt;
      sum_r      <= sum_nxt;
      count_r    <= count_nxt;
      lowest_r   <= lowest_nxt;
      highest_r  <= highest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_rtt_sample;
      rd_vld_r <= ring_vld_r[slot_r];
    end
    if (cmd.update) begin
      quo_r     <= sum_nxt;
      rem_r     <= '0;
      div_cnt_r <= DIV_CNT_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      quo_r     <= quo_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
    if (cmd.load_out) begin
      // the mean never exceeds the largest sample, so the low bits hold it
      out_average_r <= quo_r[RTT_W-1:0];
      out_minimum_r <= lowest_r;
      out_maximum_r <= highest_r;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for rtt_window_statistics_top, the sliding-window rtt statistics
// depends on rws_pkg for widths and window depth, and on the rtl of the block itself
module tb_top;
  import rws_pkg::*;

  // flow-control phases applied to both channels
  typedef enum logic [1:0] {
    FLOW_FREE,        // no idling on either side
    FLOW_SENDER_IDLE, // sender idle most cycles
    FLOW_SINK_STALL,  // receiver stalling most cycles
    FLOW_BOTH         // light idling on both sides
  } flow_e;

  // one queued probe for the driver
  typedef struct {
    logic [RTT_W-1:0] sample;
    flow_e            flow;
    bit               drain_first;  // hold off until every pending result has come back
  } probe_t;

  // one set of window statistics as the block reports it
  typedef struct packed {
    logic [RTT_W-1:0] average;
    logic [RTT_W-1:0] minimum;
    logic [RTT_W-1:0] maximum;
  } rtt_stats_t;

  localparam int unsigned BUSY_PCT  = 83;
  localparam int unsigned LIGHT_PCT = 10;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PHASE_LEN = 200;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [RTT_W-1:0] in_rtt_sample = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [RTT_W-1:0] out_average_rtt;
  logic [RTT_W-1:0] out_minimum_rtt;
  logic [RTT_W-1:0] out_maximum_rtt;

  flow_e            flow = FLOW_FREE;
  probe_t           probe_backlog [$];
  rtt_stats_t       stats_due [$];

  // own copy of the window state, advanced on every nonzero sample transfer
  logic [RTT_W-1:0] ring_samples [WINDOW];
  int unsigned      ring_slot;
  logic [SUM_W-1:0] ring_sum;
  logic [CNT_W-1:0] ring_count;
  logic [RTT_W-1:0] min_seen;
  logic [RTT_W-1:0] max_seen;

  int unsigned      samples_taken = 0;
  int unsigned      zeros_taken = 0;
  int unsigned      results_checked = 0;
  int unsigned      error_count = 0;
  int unsigned      probe_total;

  rtt_window_statistics_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rtt_sample   (in_rtt_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average_rtt (out_average_rtt),
    .out_minimum_rtt (out_minimum_rtt),
    .out_maximum_rtt (out_maximum_rtt)
  );

  always #5 clk = ~clk;

  // advance the window by one sample; returns 1 when the sample yields a result
  function automatic bit window_update(input logic [RTT_W-1:0] sample,
                                       output rtt_stats_t stats);
    logic [RTT_W-1:0] evicted;
    logic [SUM_W-1:0] mean;
    stats = '0;
    // a zero sample is no measurement and leaves everything alone
    if (sample == '0) return 1'b0;
    evicted = ring_samples[ring_slot];
    // an empty slot grows the count, a full one gives its value back from the sum
    if (evicted == '0) ring_count = ring_count + 1'b1;
    else ring_sum = ring_sum - evicted;
    ring_sum = ring_sum + sample;
    ring_samples[ring_slot] = sample;
    ring_slot = (ring_slot + 1) % WINDOW;
    if (sample < min_seen) min_seen = sample;
    if (sample > max_seen) max_seen = sample;
    mean = (ring_count != '0) ? ring_sum / ring_count : '0;
    stats.average = mean[RTT_W-1:0];
    stats.minimum = min_seen;
    stats.maximum = max_seen;
    return 1'b1;
  endfunction

  // rtt values spread over zero, typical delays, powers of two and their complements and the top of the range
  function automatic logic [RTT_W-1:0] random_rtt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2, 3:    return $urandom;
      4, 5:    return $urandom_range(1, 1000);
      6:       return $urandom_range(1000, 2000000);
      7:       return 32'h1 << $urandom_range(0, 31);
      8:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom_range(1, 15);
    endcase
  endfunction

  function automatic bit idles_now(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic queue_probe(input logic [RTT_W-1:0] sample, input flow_e mode,
                             input bit drain_first);
    probe_t p;
    p.sample      = sample;
    p.flow        = mode;
    p.drain_first = drain_first;
    probe_backlog.push_back(p);
  endtask

  // driver: offers the next probe when the channel slot is free, holds it while stalled
  always @(posedge clk) begin : sample_driver
    probe_t     p;
    rtt_stats_t stats;
    bit         pause;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // transfer on the input channel: work out what the block should report
      if (in_valid && !in_stall) begin
        samples_taken++;
        if (window_update(in_rtt_sample, stats)) stats_due.push_back(stats);
        else zeros_taken++;
      end
      if (!in_valid || !in_stall) begin
        pause = (flow == FLOW_SENDER_IDLE) ? idles_now(BUSY_PCT) :
                (flow == FLOW_BOTH)        ? idles_now(LIGHT_PCT) : 1'b0;
        if (probe_backlog.size() != 0 && !pause &&
            !(probe_backlog[0].drain_first && stats_due.size() != 0)) begin
          p = probe_backlog.pop_front();
          in_valid      <= 1'b1;
          in_rtt_sample <= p.sample;
          flow          <= p.flow;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transfer with the oldest pending expectation
  always @(posedge clk) begin : stats_monitor
    rtt_stats_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $error("unexpected result: average_rtt %0d minimum_rtt %0d maximum_rtt %0d",
                 out_average_rtt, out_minimum_rtt, out_maximum_rtt);
          error_count++;
        end else begin
          want = stats_due.pop_front();
          results_checked++;
          if (out_average_rtt !== want.average) begin
            $error("average_rtt: expected %0d, actual %0d", want.average, out_average_rtt);
            error_count++;
          end
          if (out_minimum_rtt !== want.minimum) begin
            $error("minimum_rtt: expected %0d, actual %0d", want.minimum, out_minimum_rtt);
            error_count++;
          end
          if (out_maximum_rtt !== want.maximum) begin
            $error("maximum_rtt: expected %0d, actual %0d", want.maximum, out_maximum_rtt);
            error_count++;
          end
        end
      end
      out_stall <= (flow == FLOW_SINK_STALL) ? idles_now(BUSY_PCT) :
                   (flow == FLOW_BOTH)       ? idles_now(LIGHT_PCT) : 1'b0;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [RTT_W-1:0] directed_rtt [$];
    logic [RTT_W-1:0] base;
    logic [RTT_W-1:0] sample;
    int unsigned      burst;
    int unsigned      made;
    flow_e            mode;

    for (int i = 0; i < WINDOW; i++) ring_samples[i] = '0;
    ring_slot  = 0;
    ring_sum   = '0;
    ring_count = '0;
    min_seen   = '1;
    max_seen   = '0;

    // directed: zero on an empty window, all ones as first sample (minimum stays all ones),
    // a full window of near-maximum values so the sum needs its top bits, eviction once
    // full, smallest nonzero value, alternating bit patterns, zeros between real samples
    directed_rtt = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h2, 32'h0,
                     32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd1000};
    foreach (directed_rtt[i]) queue_probe(directed_rtt[i], FLOW_FREE, 1'b0);

    // random: bursts of similar rtts as a real link gives, with stray values and zeros
    for (int ph = 0; ph < PHASES; ph++) begin
      mode = flow_e'(ph % 4);
      made = 0;
      // every phase change waits for the pipeline to empty first
      queue_probe(random_rtt(), mode, 1'b1);
      while (made < PHASE_LEN) begin
        base  = random_rtt();
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 9) == 0) sample = '0;
          else if ($urandom_range(0, 3) == 0) sample = random_rtt();
          else sample = base ^ RTT_W'($urandom_range(0, 255));
          queue_probe(sample, mode, $urandom_range(0, 99) == 0);
          made++;
        end
      end
    end
    probe_total = probe_backlog.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_taken != probe_total) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    // room for a stray result beyond the pipeline latency
    repeat (100) @(posedge clk);

    if (stats_due.size() != 0) begin
      $error("%0d expected results never arrived", stats_due.size());
      error_count++;
    end
    $display("tb_top: %0d samples transferred, %0d of them zero, %0d results checked",
             samples_taken, zeros_taken, results_checked);
    $display("tb_top: flow phases free, sender idle, receiver stall and both sides idle");
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #5000000;
    $display("tb_top: timeout with %0d results outstanding", stats_due.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rws_pkg.sv
rtl/core/rws_ctrl.sv
rtl/core/rws_datapath.sv
rtl/core/rtt_window_statistics_top.sv
verif/tb_top.sv
